>>> sv/brle_pkg.sv
// Shared types and constants of the bit run-length encoder.
package brle_pkg;

    // Depth of the queue between the front and the back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Run count at which the next equal bit wraps the run
    localparam logic [7:0] RUN_WRAP   = 8'hFF;
    localparam logic [7:0] RUN_CLEAR  = 8'h00;
    localparam logic [7:0] RUN_START  = 8'h01;
    // Expected bit after reset: the ones run comes first
    localparam logic       BIT_RESET  = 1'b1;
    // First scanned bit position of a byte
    localparam logic [2:0] POS_FIRST  = 3'd7;
    localparam logic [2:0] POS_LAST   = 3'd0;

    // One bitmap byte as it travels through the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // One emitted run count
    typedef struct packed {
        logic [7:0] run_byte;
        logic       stream_end;
        logic       last_of_item;
    } result_t;

    // Queue status seen by its writer and reader
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> sv/brle_if.sv
// Handshake channels of the encoder: bitmap bytes in, run counts out.
interface brle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface brle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] run_byte;
    logic       stream_end;
    logic       last_of_item;

    modport source (output valid, output run_byte, output stream_end,
                    output last_of_item, input ready);
    modport sink   (input valid, input run_byte, input stream_end,
                    input last_of_item, output ready);
endinterface

>>> sv/bit_run_length_encoder.sv
// A byte passes the front hold register and a queue entry before it reaches the scanner; each count
// is registered out once the next count or the end of its byte is found.
// The scanner handles one bit, or the flush after a byte marked last, per cycle unless a
// pending count waits on a stalled output.
// Reset (asynchronous, active low): expected bit 1, count 0, queue and outputs empty.
module bit_run_length_encoder (
    input  logic        clk,
    input  logic        rst_n,
    brle_in_if.sink     bitmap,
    brle_out_if.source  runs
);

    brle_pkg::item_t     in_item;
    brle_pkg::item_t     push_item;
    brle_pkg::item_t     pop_item;
    brle_pkg::q_status_t q_status;
    brle_pkg::result_t   result;
    logic                q_push;
    logic                q_pop;

    assign in_item.data_byte = bitmap.data_byte;
    assign in_item.last_byte = bitmap.last_byte;

    brle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bitmap.valid),
        .in_ready (bitmap.ready),
        .in_item  (in_item),
        .q_status (q_status),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    brle_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    brle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_item     (pop_item),
        .q_pop      (q_pop),
        .out_valid  (runs.valid),
        .out_ready  (runs.ready),
        .out_result (result)
    );

    assign runs.run_byte     = result.run_byte;
    assign runs.stream_end   = result.stream_end;
    assign runs.last_of_item = result.last_of_item;

endmodule

>>> sv/brle_front.sv
// Front stage: registers each accepted bitmap beat and hands it to the queue.
module brle_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  brle_pkg::item_t     in_item,
    input  brle_pkg::q_status_t q_status,
    output logic                q_push,
    output brle_pkg::item_t     q_item
);

    logic            hold_valid_reg;
    logic            hold_valid_next;
    brle_pkg::item_t hold_item_reg;

    // Forward the held beat whenever the queue has room
    assign q_push   = hold_valid_reg && !q_status.full;
    assign q_item   = hold_item_reg;
    assign in_ready = !hold_valid_reg || !q_status.full;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_valid && in_ready)
        begin
            hold_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_item_reg <= in_item;
        end
    end

endmodule

>>> sv/brle_fifo.sv
// Short queue of bitmap items between the front and the back.
module brle_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  brle_pkg::item_t     push_item,
    input  logic                pop,
    output brle_pkg::item_t     pop_item,
    output brle_pkg::q_status_t status
);

    brle_pkg::item_t                   mem [brle_pkg::QDEPTH];
    logic [brle_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [brle_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [brle_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [brle_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [brle_pkg::QCNT_W-1:0]       count_reg;
    logic [brle_pkg::QCNT_W-1:0]       count_next;

    assign status.full  = (count_reg == brle_pkg::QCNT_W'(brle_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_item     = mem[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == brle_pkg::QPTR_W'(brle_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == brle_pkg::QPTR_W'(brle_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> sv/brle_back.sv
// Back stage: scans one bit per cycle unless its result path stalls, counts runs and drives result beats.
module brle_back (
    input  logic                clk,
    input  logic                rst_n,
    input  brle_pkg::q_status_t q_status,
    input  brle_pkg::item_t     q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output brle_pkg::result_t   out_result
);

    // Scan state
    logic                busy_reg,  busy_next;
    logic                flush_reg, flush_next;
    logic [2:0]          pos_reg,   pos_next;
    brle_pkg::item_t     item_reg;
    logic                cur_bit_reg, cur_bit_next;
    logic [7:0]          count_reg,   count_next;

    // Pending result, held until it is known whether it ends its item
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_last_reg,  pend_last_next;
    logic [7:0]          pend_run_reg;
    logic                pend_end_reg;

    // Output register
    logic                out_valid_reg, out_valid_next;
    brle_pkg::result_t   out_result_reg;

    logic                scan_bit;
    logic                gen;
    logic [7:0]          gen_run;
    logic                gen_end;
    logic                final_step;
    logic                can_push;
    logic                push;
    logic                step_en;

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    // Classify the current step
    always_comb
    begin
        scan_bit     = item_reg.data_byte[pos_reg];
        count_next   = count_reg;
        cur_bit_next = cur_bit_reg;
        gen          = 1'b0;
        gen_run      = count_reg;
        gen_end      = 1'b0;
        if (flush_reg)
        begin
            gen          = 1'b1;
            gen_end      = 1'b1;
            count_next   = brle_pkg::RUN_CLEAR;
            cur_bit_next = brle_pkg::BIT_RESET;
        end
        else if (scan_bit == cur_bit_reg)
        begin
            if (count_reg == brle_pkg::RUN_WRAP)
            begin
                gen        = 1'b1;
                gen_run    = brle_pkg::RUN_CLEAR;
                count_next = brle_pkg::RUN_CLEAR;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            gen          = 1'b1;
            count_next   = brle_pkg::RUN_START;
            cur_bit_next = ~cur_bit_reg;
        end
    end

    assign final_step = flush_reg || ((pos_reg == brle_pkg::POS_LAST) && !item_reg.last_byte);
    assign can_push   = !out_valid_reg || out_ready;
    assign push       = pend_valid_reg && can_push && (pend_last_reg || gen);
    assign step_en    = busy_reg && (!gen || !pend_valid_reg || push);
    assign q_pop      = !q_status.empty && (!busy_reg || (step_en && final_step));

    // Sequence bit positions and the flush step
    always_comb
    begin
        busy_next  = busy_reg;
        flush_next = flush_reg;
        pos_next   = pos_reg;
        if (step_en)
        begin
            pos_next = pos_reg - 1'b1;
            if (final_step)
            begin
                busy_next  = 1'b0;
                flush_next = 1'b0;
            end
            else if (pos_reg == brle_pkg::POS_LAST)
            begin
                flush_next = 1'b1;
            end
        end
        if (q_pop)
        begin
            busy_next  = 1'b1;
            flush_next = 1'b0;
            pos_next   = brle_pkg::POS_FIRST;
        end
    end

    // Update pending slot
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;
        if (step_en && gen)
        begin
            pend_valid_next = 1'b1;
            pend_last_next  = final_step;
        end
        else if (push)
        begin
            pend_valid_next = 1'b0;
        end
        else if (step_en && final_step && pend_valid_reg)
        begin
            pend_last_next = 1'b1;
        end
    end

    // Load output register from the pending slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            flush_reg      <= 1'b0;
            pos_reg        <= brle_pkg::POS_FIRST;
            cur_bit_reg    <= brle_pkg::BIT_RESET;
            count_reg      <= brle_pkg::RUN_CLEAR;
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            flush_reg      <= flush_next;
            pos_reg        <= pos_next;
            pend_valid_reg <= pend_valid_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
            if (step_en)
            begin
                cur_bit_reg <= cur_bit_next;
                count_reg   <= count_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (step_en && gen)
        begin
            pend_run_reg <= gen_run;
            pend_end_reg <= gen_end;
        end
        if (push)
        begin
            // a newer count of the same byte means this one is not its last
            out_result_reg.run_byte     <= pend_run_reg;
            out_result_reg.stream_end   <= pend_end_reg;
            out_result_reg.last_of_item <= pend_last_reg;
        end
    end

endmodule

>>> sv/brle_checker.sv
// Port-level checks of the encoder, bound to the top level.
module brle_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] run_byte,
    input logic       stream_end,
    input logic       last_of_item
);

    // The flushed count always closes its byte
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> last_of_item)
        else $error("stream end beat without last_of_item");

    // Nothing is offered right after reset
    a_quiet_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result beat right after reset");

    // A stalled beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(run_byte)
            && $stable(stream_end) && $stable(last_of_item))
        else $error("stalled result beat changed");

endmodule

bind bit_run_length_encoder brle_checker u_brle_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (runs.valid),
    .out_ready    (runs.ready),
    .run_byte     (runs.run_byte),
    .stream_end   (runs.stream_end),
    .last_of_item (runs.last_of_item)
);
